@@ src/phh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phh_pkg
// Shared types, sizes and helpers for the pile height histogram unit.
// ----------------------------------------------------------------------------
package phh_pkg;

  localparam int NUM_BINS  = 64;
  localparam int POS_WIDTH = 32;

  localparam int BIN_AW    = $clog2(NUM_BINS);
  // adder operand width: wide enough for a position gap and a pile count
  localparam int ADD_W     = (POS_WIDTH > 32) ? POS_WIDTH : 32;
  localparam int SUM_W     = ADD_W + 1;
  // bin index compare width, holds NUM_BINS itself
  localparam int IDX_CMP_W = ((BIN_AW > 6) ? BIN_AW : 6) + 1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_PREP,
    S_ADD_GAP,
    S_ADD_BUMP,
    S_ADD_CLOSE,
    S_RD_ISSUE,
    S_RD_EMIT,
    S_ZERO_EMIT
  } state_t;

  typedef struct packed {
    logic latch;      // capture input fields
    logic add_prep;   // gap/tail compute, run sum, bin read
    logic add_gap;    // bin zero += gap
    logic add_bump;   // pile bin += 1
    logic add_close;  // bin zero += tail, run state update, emit
    logic rd_issue;   // bin read for a read op
    logic rd_emit;    // emit bin value
    logic zero_emit;  // emit zero result
    logic clear;      // empty all bins
  } phh_cmd_t;

  // saturating 32-bit add of a nonnegative operand
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [ADD_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s[SUM_W-1:32] != '0) begin
      return '1;
    end
    return s[31:0];
  endfunction

endpackage

@@ src/phh_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phh_ctrl
// Sequencer for the histogram unit: walks each op through its steps.
// ----------------------------------------------------------------------------
module phh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_op,
  output logic              busy,
  output phh_pkg::phh_cmd_t cmd
);

  phh_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= phh_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      phh_pkg::S_IDLE: begin
        if (start) begin
          case (phh_pkg::op_t'(in_op))
            phh_pkg::OP_ADD:   state_nxt = phh_pkg::S_ADD_PREP;
            phh_pkg::OP_READ:  state_nxt = phh_pkg::S_RD_ISSUE;
            default:           state_nxt = phh_pkg::S_ZERO_EMIT;
          endcase
        end
      end
      phh_pkg::S_ADD_PREP:  state_nxt = phh_pkg::S_ADD_GAP;
      phh_pkg::S_ADD_GAP:   state_nxt = phh_pkg::S_ADD_BUMP;
      phh_pkg::S_ADD_BUMP:  state_nxt = phh_pkg::S_ADD_CLOSE;
      phh_pkg::S_ADD_CLOSE: state_nxt = phh_pkg::S_IDLE;
      phh_pkg::S_RD_ISSUE:  state_nxt = phh_pkg::S_RD_EMIT;
      phh_pkg::S_RD_EMIT:   state_nxt = phh_pkg::S_IDLE;
      phh_pkg::S_ZERO_EMIT: state_nxt = phh_pkg::S_IDLE;
      default:              state_nxt = phh_pkg::S_IDLE;
    endcase
  end

  logic clear_pending_r, clear_pending_nxt;

  // remembers that the zero-result op was a clear
  always_comb begin
    clear_pending_nxt = clear_pending_r;
    if (state_r == phh_pkg::S_IDLE && start) begin
      clear_pending_nxt = (phh_pkg::op_t'(in_op) == phh_pkg::OP_CLEAR);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_pending_r <= 1'b0;
    end else begin
      clear_pending_r <= clear_pending_nxt;
    end
  end

  always_comb begin
    busy = (state_r != phh_pkg::S_IDLE);
    cmd  = '0;
    case (state_r)
      phh_pkg::S_IDLE:      cmd.latch     = start;
      phh_pkg::S_ADD_PREP:  cmd.add_prep  = 1'b1;
      phh_pkg::S_ADD_GAP:   cmd.add_gap   = 1'b1;
      phh_pkg::S_ADD_BUMP:  cmd.add_bump  = 1'b1;
      phh_pkg::S_ADD_CLOSE: cmd.add_close = 1'b1;
      phh_pkg::S_RD_ISSUE:  cmd.rd_issue  = 1'b1;
      phh_pkg::S_RD_EMIT:   cmd.rd_emit   = 1'b1;
      phh_pkg::S_ZERO_EMIT: begin
        cmd.zero_emit = 1'b1;
        cmd.clear     = clear_pending_r;
      end
      default: cmd = '0;
    endcase
  end

  // every accepted op leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("op accepted but sequencer stayed idle");

  // at most one result emitted per cycle
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.add_close, cmd.rd_emit, cmd.zero_emit}))
    else $error("more than one emit command");

  // add sequence runs its steps in order
  a_add_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_prep |=> cmd.add_gap ##1 cmd.add_bump ##1 cmd.add_close)
    else $error("add steps out of order");

endmodule

@@ src/phh_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phh_datapath
// Bin memory, bin zero accumulator, run state and result register.
// ----------------------------------------------------------------------------
module phh_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  phh_pkg::phh_cmd_t cmd,
  input  logic [31:0]       in_position,
  input  logic [15:0]       in_pile_count,
  input  logic              in_run_last,
  input  logic [31:0]       in_target_length,
  input  logic [5:0]        in_bin_index,
  output logic              out_valid,
  output logic [31:0]       out_value,
  output logic              out_run_done
);

  localparam int PW = phh_pkg::POS_WIDTH;
  localparam int AW = phh_pkg::BIN_AW;
  localparam int NB = phh_pkg::NUM_BINS;

  // captured op fields
  logic [PW-1:0] pos_r, tlen_r;
  logic [15:0]   cnt_r;
  logic          last_r;
  logic [AW-1:0] bin_r;
  logic [AW-1:0] idx_r;
  logic          idx_ok_r;

  logic [phh_pkg::ADD_W-1:0]     pos_ext, tlen_ext;
  logic [phh_pkg::IDX_CMP_W-1:0] idx_ext;

  assign pos_ext  = phh_pkg::ADD_W'(in_position);
  assign tlen_ext = phh_pkg::ADD_W'(in_target_length);
  assign idx_ext  = phh_pkg::IDX_CMP_W'(in_bin_index);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pos_r  <= pos_ext[PW-1:0];
      tlen_r <= tlen_ext[PW-1:0];
      cnt_r  <= in_pile_count;
      last_r <= in_run_last;
      if (in_pile_count >= 16'(NB - 1)) begin
        bin_r <= AW'(NB - 1);
      end else begin
        bin_r <= in_pile_count[AW-1:0];
      end
      idx_r    <= idx_ext[AW-1:0];
      idx_ok_r <= (idx_ext < phh_pkg::IDX_CMP_W'(NB));
    end
  end

  // gap and tail lengths, registered before the bin zero adds
  logic [PW-1:0] gap_r, tail_r;

  // run state
  logic [PW-1:0] prev_r, prev_nxt;
  logic          in_run_r, in_run_nxt;
  logic [31:0]   run_sum_r, run_sum_nxt;

  always_ff @(posedge clk) begin
    if (cmd.add_prep) begin
      if (in_run_r && pos_r > prev_r) begin
        gap_r <= pos_r - prev_r - PW'(1);
      end else begin
        gap_r <= '0;
      end
      if (last_r && tlen_r > pos_r) begin
        tail_r <= tlen_r - pos_r - PW'(1);
      end else begin
        tail_r <= '0;
      end
    end
  end

  always_comb begin
    prev_nxt    = prev_r;
    in_run_nxt  = in_run_r;
    run_sum_nxt = run_sum_r;
    if (cmd.add_prep) begin
      run_sum_nxt = phh_pkg::sat_add(run_sum_r, phh_pkg::ADD_W'(cnt_r));
    end
    if (cmd.add_close) begin
      if (last_r) begin
        prev_nxt    = '0;
        in_run_nxt  = 1'b0;
        run_sum_nxt = '0;
      end else begin
        prev_nxt   = pos_r;
        in_run_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      in_run_r  <= 1'b0;
      run_sum_r <= '0;
    end else begin
      prev_r    <= prev_nxt;
      in_run_r  <= in_run_nxt;
      run_sum_r <= run_sum_nxt;
    end
  end

  // bin memory (entry zero lives in bin0_r), valid bits give the zero reset
  logic [31:0]   mem [NB];
  logic [NB-1:0] valid_r, valid_nxt;
  logic [31:0]   rd_data_r;
  logic          rd_vld_r;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_ra;
  logic [31:0]   mem_wd;
  logic [31:0]   bump_base;

  assign mem_re    = cmd.add_prep | cmd.rd_issue;
  assign mem_ra    = cmd.add_prep ? bin_r : idx_r;
  assign mem_we    = cmd.add_bump && (bin_r != '0);
  assign bump_base = rd_vld_r ? rd_data_r : 32'd0;
  assign mem_wd    = phh_pkg::sat_add(bump_base, phh_pkg::ADD_W'(1));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[bin_r] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
      rd_vld_r  <= valid_r[mem_ra];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.clear) begin
      valid_nxt = '0;
    end else if (mem_we) begin
      valid_nxt[bin_r] = 1'b1;
    end
  end

  // bin zero accumulator
  logic [31:0] bin0_r, bin0_nxt;

  always_comb begin
    bin0_nxt = bin0_r;
    if (cmd.clear) begin
      bin0_nxt = '0;
    end else if (cmd.add_gap) begin
      bin0_nxt = phh_pkg::sat_add(bin0_r, phh_pkg::ADD_W'(gap_r));
    end else if (cmd.add_bump && bin_r == '0) begin
      bin0_nxt = phh_pkg::sat_add(bin0_r, phh_pkg::ADD_W'(1));
    end else if (cmd.add_close) begin
      bin0_nxt = phh_pkg::sat_add(bin0_r, phh_pkg::ADD_W'(tail_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      bin0_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      bin0_r  <= bin0_nxt;
    end
  end

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_value_r;
  logic        out_run_done_r;
  logic [31:0] rd_value;

  always_comb begin
    if (!idx_ok_r) begin
      rd_value = '0;
    end else if (idx_r == '0) begin
      rd_value = bin0_r;
    end else begin
      rd_value = rd_vld_r ? rd_data_r : 32'd0;
    end
  end

  assign out_valid_nxt = cmd.add_close | cmd.rd_emit | cmd.zero_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_close) begin
      out_value_r    <= run_sum_r;
      out_run_done_r <= last_r;
    end else if (cmd.rd_emit) begin
      out_value_r    <= rd_value;
      out_run_done_r <= 1'b0;
    end else if (cmd.zero_emit) begin
      out_value_r    <= '0;
      out_run_done_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_run_done = out_run_done_r;

  // a clear leaves every bin empty
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (valid_r == '0) && (bin0_r == '0))
    else $error("bins not empty after clear");

  // a closed run leaves no run state behind
  a_run_close: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_close && last_r |=> !in_run_r && (run_sum_r == '0) && out_run_done)
    else $error("run state left after last pile");

  // run_done only on a result that follows an add close
  a_done_from_add: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_done |-> $past(cmd.add_close))
    else $error("run_done without add close");

endmodule

@@ src/pile_height_histogram_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pile_height_histogram_unit
// Histogram of pile heights over position-sorted runs of pile entries.
// ----------------------------------------------------------------------------
// Steps per op: add runs prep, gap, bump and close; read runs issue and emit;
// clear and unused op run a single emit step. busy stays high until the op's
// last step, so a new op is taken only after the last one is done; the bin
// read-modify-write and the saturating bin zero updates make up the add steps.
// Results show for one cycle on out_valid and cannot be stalled; the next op
// may be accepted in the same cycle a result is shown.
// Reset (synchronous, rst_n low) empties all bins at once through per-bin
// valid bits and clears the run state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pile_height_histogram_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel: transfer when start is high and busy is low
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_position,
  input  logic [15:0] in_pile_count,
  input  logic        in_run_last,
  input  logic [31:0] in_target_length,
  input  logic [5:0]  in_bin_index,
  // result channel: one transfer per op, one cycle per result
  output logic        out_valid,
  output logic [31:0] out_value,
  output logic        out_run_done
);

  phh_pkg::phh_cmd_t cmd;

  // sequencer: decodes the op on transfer and steps the datapath
  phh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath: bin memory, bin zero register, run state, result register
  phh_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_position      (in_position),
    .in_pile_count    (in_pile_count),
    .in_run_last      (in_run_last),
    .in_target_length (in_target_length),
    .in_bin_index     (in_bin_index),
    .out_valid        (out_valid),
    .out_value        (out_value),
    .out_run_done     (out_run_done)
  );

endmodule

@@ tb/phh_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phh_result_checker
// Watches both channels of the pile height histogram unit. It keeps a shadow
// histogram and run state and compares each result transfer, field by field,
// with the oldest predicted result.
// ----------------------------------------------------------------------------
module phh_result_checker
  import phh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_position,
  input  logic [15:0] in_pile_count,
  input  logic        in_run_last,
  input  logic [31:0] in_target_length,
  input  logic [5:0]  in_bin_index,
  input  logic        out_valid,
  input  logic [31:0] out_value,
  input  logic        out_run_done,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] value;
    logic        run_done;
  } pile_result_t;

  logic [31:0]          shadow_bins [NUM_BINS];
  logic [POS_WIDTH-1:0] last_pos;
  logic                 run_open;
  logic [31:0]          read_sum;
  pile_result_t         due_q [$];

  function automatic logic [31:0] sat32(input logic [31:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = {32'd0, a} + b;
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Shadow update for one accepted op; returns the result it should produce.
  task automatic predict_pile_op(input logic [1:0] op_bits, input logic [31:0] pos_in,
                                 input logic [15:0] cnt, input logic last,
                                 input logic [31:0] tlen_in, input logic [5:0] idx,
                                 output pile_result_t res);
    op_t                  op;
    logic [POS_WIDTH-1:0] pos;
    logic [POS_WIDTH-1:0] tlen;
    int unsigned          bin;
    op   = op_t'(op_bits);
    pos  = pos_in[POS_WIDTH-1:0];
    tlen = tlen_in[POS_WIDTH-1:0];
    res  = '0;
    case (op)
      OP_ADD: begin
        bin = (cnt >= NUM_BINS - 1) ? NUM_BINS - 1 : cnt;
        if (run_open && pos > last_pos) begin
          shadow_bins[0] = sat32(shadow_bins[0], 64'(pos) - 64'(last_pos) - 64'd1);
        end
        shadow_bins[bin] = sat32(shadow_bins[bin], 64'd1);
        read_sum  = sat32(read_sum, 64'(cnt));
        res.value = read_sum;
        if (last) begin
          if (tlen > pos) begin
            shadow_bins[0] = sat32(shadow_bins[0], 64'(tlen) - 64'(pos) - 64'd1);
          end
          res.run_done = 1'b1;
          run_open     = 1'b0;
          read_sum     = '0;
          last_pos     = '0;
        end else begin
          last_pos = pos;
          run_open = 1'b1;
        end
      end
      OP_READ: begin
        if (int'(idx) < NUM_BINS) begin
          res.value = shadow_bins[idx];
        end
      end
      OP_CLEAR: begin
        foreach (shadow_bins[i]) shadow_bins[i] = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    pile_result_t want;
    pile_result_t got;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      foreach (shadow_bins[i]) shadow_bins[i] = '0;
      last_pos = '0;
      run_open = 1'b0;
      read_sum = '0;
      due_q.delete();
      fail_count <= 0;
    end else begin
      // retire first: a result and a new transfer can share an edge
      if (out_valid) begin
        got = {out_value, out_run_done};
        if (due_q.size() == 0) begin
          $display("%0t: result with none expected: value %h run_done %b",
                   $time, got.value, got.run_done);
          errs++;
        end else begin
          want = due_q.pop_front();
          if (got.value !== want.value) begin
            $display("%0t: value mismatch: expected %h actual %h",
                     $time, want.value, got.value);
            errs++;
          end
          if (got.run_done !== want.run_done) begin
            $display("%0t: run_done mismatch: expected %b actual %b",
                     $time, want.run_done, got.run_done);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        predict_pile_op(in_op, in_position, in_pile_count, in_run_last,
                        in_target_length, in_bin_index, want);
        due_q = {due_q, want};
      end
      fail_count <= fail_count + errs;
    end
    pending <= due_q.size();
  end

endmodule

@@ tb/tb_pile_height_histogram_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pile_height_histogram_unit
// Drives directed and random ops into the pile height histogram unit with
// random sender gaps; a checker beside the block predicts and compares every
// result and reports its failure count here for the verdict.
// ----------------------------------------------------------------------------
module tb_pile_height_histogram_unit;
  import phh_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_ITEMS  = 1000;
  // short run of max-count piles sent with no sender gaps
  localparam int B2B_ITEMS     = 16;
  // longest quiet stretch of a correct run is a sender gap plus an add
  localparam int QUIET_LIMIT   = 1000;
  localparam int TAIL_CYCLES   = 20;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [31:0] in_position;
  logic [15:0] in_pile_count;
  logic        in_run_last;
  logic [31:0] in_target_length;
  logic [5:0]  in_bin_index;
  logic        out_valid;
  logic [31:0] out_value;
  logic        out_run_done;

  int fail_count;
  int pending;
  int items_sent;
  bit no_idle;   // suppresses the sender gap for back-to-back stretches

  pile_height_histogram_unit u_top (.*);

  phh_result_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog: ends the run with FAIL once a quiet stretch, with no transfer on
  // either channel, reaches QUIET_LIMIT.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  // One input transfer. Entered just after a rising edge; the gap is drawn
  // per item, fields change on the falling edge, and the task returns at the
  // rising edge that accepted the item. start stays high when the next item
  // follows with no gap, so it is never dropped and raised in one step.
  task automatic send_op(input op_t op, input logic [31:0] pos, input logic [15:0] cnt,
                         input logic last, input logic [31:0] tlen, input logic [5:0] idx);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start            <= 1'b1;
    in_op            <= op;
    in_position      <= pos;
    in_pile_count    <= cnt;
    in_run_last      <= last;
    in_target_length <= tlen;
    in_bin_index     <= idx;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Hold the sender off until every predicted result has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Read op with all unused fields random, so their bits toggle too.
  task automatic read_bin(input logic [5:0] idx);
    send_op(OP_READ, $urandom, 16'($urandom), 1'($urandom), $urandom, idx);
  endtask

  // A well-formed run: mostly ascending positions with small steps, repeats
  // and the odd wild jump; counts mostly in the bin range, some full width;
  // the closing pile's target length lands past, on or away from its end.
  task automatic send_run();
    int          len;
    int          k;
    logic [31:0] pos;
    logic [15:0] cnt;
    logic [31:0] tlen;
    len = $urandom_range(1, 12);
    pos = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000);
    for (k = 0; k < len; k++) begin
      cnt = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 70));
      case ($urandom_range(0, 3))
        0:       tlen = $urandom;
        1:       tlen = pos;
        default: tlen = pos + $urandom_range(1, 500);
      endcase
      send_op(OP_ADD, pos, cnt, k == len - 1, tlen, 6'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        read_bin(6'($urandom));
      end else if ($urandom_range(0, 49) == 0) begin
        // clear in the middle of a run keeps the run state
        send_op(OP_CLEAR, $urandom, 16'($urandom), 1'($urandom), $urandom, 6'($urandom));
      end
      pos = pos + (($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 4));
    end
  endtask

  initial begin : stimulus
    int i;
    int base;
    int pick;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_op            = OP_ADD;
    in_position      = '0;
    in_pile_count    = '0;
    in_run_last      = 1'b0;
    in_target_length = '0;
    in_bin_index     = '0;
    no_idle          = 1'b0;
    items_sent       = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    read_bin(6'd0);                                            // empty after reset
    send_op(OP_NONE, '1, '1, 1'b1, '1, '1);                    // unused op, all ones
    send_op(OP_ADD, 32'd10, 16'd0, 1'b0, 32'd100, 6'd0);       // zero count opens run
    send_op(OP_ADD, 32'd15, 16'd3, 1'b0, 32'd100, 6'd0);       // gap of four
    send_op(OP_ADD, 32'd15, 16'd70, 1'b0, 32'd100, 6'd0);      // repeat position, tall
    send_op(OP_ADD, 32'd12, 16'hFFFF, 1'b0, 32'd100, 6'd0);    // position goes back
    send_op(OP_CLEAR, '0, '0, 1'b0, '0, '0);                   // clear inside a run
    send_op(OP_ADD, 32'd20, 16'd63, 1'b1, 32'd20, 6'd0);       // closes, target at pos
    read_bin(6'd0);
    read_bin(6'd63);
    send_op(OP_ADD, '1, 16'd62, 1'b1, '1, 6'd0);               // lone pile at the top
    send_op(OP_ADD, 32'd0, 16'd1, 1'b0, 32'd1, 6'd0);
    send_op(OP_ADD, '1, 16'd2, 1'b1, '1, 6'd0);                // widest gap
    send_op(OP_ADD, 32'd0, 16'd1, 1'b1, '1, 6'd0);             // widest tail, bin 0 saturates
    read_bin(6'd0);
    send_op(OP_ADD, 32'd5, 16'd1, 1'b1, 32'd6, 6'd0);          // tail of zero
    read_bin(6'd1);
    read_bin(6'd2);
    read_bin(6'd62);
    send_op(OP_CLEAR, '1, '1, 1'b1, '1, '1);
    read_bin(6'd0);
    send_op(OP_NONE, '0, '0, 1'b0, '0, '0);                    // unused op, all zeros
    drain();

    // ---- back-to-back run of max counts ----
    no_idle = 1'b1;
    for (i = 0; i < B2B_ITEMS; i++) begin
      send_op(OP_ADD, i, 16'hFFFF, i == B2B_ITEMS - 1, 32'd70000, 6'($urandom));
    end
    no_idle = 1'b0;
    read_bin(6'd63);
    drain();

    // ---- random ----
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      pick    = $urandom_range(0, 99);
      if (pick < 68) begin
        send_run();
      end else if (pick < 83) begin
        read_bin(6'($urandom));
      end else if (pick < 86) begin
        send_op(OP_CLEAR, $urandom, 16'($urandom), 1'($urandom), $urandom, 6'($urandom));
      end else if (pick < 94) begin
        // noise add: any position, count and end flag
        send_op(OP_ADD, $urandom, 16'($urandom), 1'($urandom), $urandom, 6'($urandom));
      end else if (pick < 98) begin
        send_op(OP_NONE, $urandom, 16'($urandom), 1'($urandom), $urandom, 6'($urandom));
      end else begin
        drain();
        read_bin(6'($urandom));
      end
    end
    no_idle = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/phh_pkg.sv
src/phh_ctrl.sv
src/phh_datapath.sv
src/pile_height_histogram_unit.sv
tb/phh_result_checker.sv
tb/tb_pile_height_histogram_unit.sv
